### rtl/core/hash_table_engine_defines.svh
// assertion helpers for the hash table engine
`ifndef HASH_TABLE_ENGINE_DEFINES_SVH
`define HASH_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication
`define HTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hte_pkg.sv
package hte_pkg;

  localparam int SLOT_COUNT = 509;
  localparam int KEY_BYTES  = 8;
  localparam int VALUE_BITS = 32;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 32;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 3;

  localparam logic [KEY_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [KEY_W-1:0] FNV_PRIME = 64'h00000100000001b3;
  localparam int               FNV_SHIFT = 40;
  localparam logic [8:0]       FNV_LOW   = FNV_PRIME[8:0];

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
  localparam logic [VAL_W-1:0] VAL_MASK =
    (VALUE_BITS >= 32) ? {VAL_W{1'b1}} : ((32'd1 << VALUE_BITS) - 32'd1);

  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FIND   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SWAP   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DUP      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BADIDX   = 3'd4;

  typedef struct packed {
    logic              used;
    logic [KEY_W-1:0]  hash;
    logic [SLOT_W-1:0] home;
    logic [SLOT_W-1:0] entry;
    logic [CNT_W-1:0]  hcount;
  } slot_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
  } entry_word_t;

endpackage

### rtl/core/hash_table_engine.sv
// hash_table_engine: key-value store with open addressing and a dense entry array
// input channel in_valid/in_ready carries one request word: type, key, value and
// two dense indices. the output channel out_valid/out_ready carries one result
// word per request: status, found value, read key, dense index, entry total.
// steps per request: find, insert and remove hash the key (one key byte per cycle),
// reduce the hash modulo SLOT_COUNT (8 hash bits per cycle), read the home count,
// then walk the probed slots with a key compare on each hash match, and update the
// slot and entry memories; swap and read entry go through their own states, and
// clear sweeps all SLOT_COUNT (509) slots. both memories have one read and one
// write port.
// after reset the slot memory is swept with in_ready low.
// a finished word waits in the output register; the next request is taken
// meanwhile, and the engine holds its following result until out_ready frees
// the register.
`include "hash_table_engine_defines.svh"

module hash_table_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hte_pkg::REQ_W-1:0]   in_req_type,
  input  logic [hte_pkg::KEY_W-1:0]   in_key,
  input  logic [hte_pkg::VAL_W-1:0]   in_value,
  input  logic [hte_pkg::SLOT_W-1:0]  in_index_a,
  input  logic [hte_pkg::SLOT_W-1:0]  in_index_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hte_pkg::STAT_W-1:0]  out_status,
  output logic [hte_pkg::VAL_W-1:0]   out_found_value,
  output logic [hte_pkg::KEY_W-1:0]   out_read_key,
  output logic [hte_pkg::SLOT_W-1:0]  out_dense_index,
  output logic [hte_pkg::CNT_W-1:0]   out_entry_total
);

  localparam int SW = hte_pkg::SLOT_W;
  localparam int CW = hte_pkg::CNT_W;
  localparam int MOD_STEPS = hte_pkg::KEY_W / 8;
  localparam int MC_W = $clog2(MOD_STEPS);
  localparam int BI_W = $clog2(hte_pkg::KEY_BYTES + 1);
  localparam logic [SW-1:0] SLOT_LAST = SW'(hte_pkg::SLOT_COUNT - 1);
  localparam logic [CW-1:0] SLOT_N    = CW'(hte_pkg::SLOT_COUNT);
  localparam logic [SW:0]   MOD_N     = (SW + 1)'(hte_pkg::SLOT_COUNT);

  typedef enum logic [4:0] {
    ST_SWEEP, ST_IDLE, ST_HASH, ST_MOD, ST_HC, ST_PCHK, ST_PKEY, ST_MISS,
    ST_FCHK, ST_HRD, ST_HWR, ST_RM_ERD, ST_RM_SWR, ST_SW_A, ST_SW_B, ST_SW_C,
    ST_SW_D, ST_SW_E, ST_SW_F, ST_RE, ST_DONE
  } state_t;

  function automatic logic [SW-1:0] mod_chunk(input logic [SW-1:0] r, input logic [7:0] b);
    logic [SW:0]   t;
    logic [SW-1:0] acc;
    acc = r;
    for (int i = 7; i >= 0; i--) begin
      t = {acc, b[i]};
      if (t >= MOD_N) t = t - MOD_N;
      acc = t[SW-1:0];
    end
    return acc;
  endfunction

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  state_t state_r, state_nxt;
  logic clr_r, clr_nxt;
  logic [SW-1:0] sw_r, sw_nxt;
  logic [CW-1:0] stored_r, stored_nxt;
  logic [hte_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [hte_pkg::KEY_W-1:0] key_r, key_nxt, h_r, h_nxt, hk_r, hk_nxt, mw_r, mw_nxt;
  logic [hte_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [SW-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic [BI_W-1:0] bi_r, bi_nxt;
  logic [MC_W-1:0] mc_r, mc_nxt;
  logic [SW-1:0] home_r, home_nxt, s_r, s_nxt, first_r, first_nxt;
  logic [SW-1:0] e_r, e_nxt, fs_r, fs_nxt, ls_r, ls_nxt;
  logic [CW-1:0] left_r, left_nxt, n_r, n_nxt;
  logic hf_r, hf_nxt;
  hte_pkg::slot_word_t fw_r, fw_nxt;
  hte_pkg::entry_word_t ea_r, ea_nxt, eb_r, eb_nxt;
  logic [hte_pkg::STAT_W-1:0] rs_r, rs_nxt;
  logic [hte_pkg::VAL_W-1:0] rv_r, rv_nxt;
  logic [hte_pkg::KEY_W-1:0] rk_r, rk_nxt;
  logic [SW-1:0] rd_r, rd_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [hte_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [hte_pkg::VAL_W-1:0] out_fval_r, out_fval_nxt;
  logic [hte_pkg::KEY_W-1:0] out_fkey_r, out_fkey_nxt;
  logic [SW-1:0] out_didx_r, out_didx_nxt;
  logic [CW-1:0] out_total_r, out_total_nxt;

  hte_pkg::slot_word_t slot_mem [hte_pkg::SLOT_COUNT];
  hte_pkg::slot_word_t slot_rd_r, slot_wd;
  logic slot_we, slot_re;
  logic [SW-1:0] slot_wa, slot_ra;
  hte_pkg::entry_word_t entry_mem [hte_pkg::SLOT_COUNT];
  hte_pkg::entry_word_t entry_rd_r, entry_wd;
  logic entry_we, entry_re;
  logic [SW-1:0] entry_wa, entry_ra;

  logic [hte_pkg::KEY_W-1:0] hx;
  logic hit_home;
  logic [CW-1:0] left_dec, n_adv, last_cnt;
  logic [SW-1:0] s_adv;
  logic in_acc;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_rd_r <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (entry_we) entry_mem[entry_wa] <= entry_wd;
    if (entry_re) entry_rd_r <= entry_mem[entry_ra];
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign hx       = h_r ^ {56'd0, hk_r[7:0]};
  assign hit_home = slot_rd_r.used && (slot_rd_r.home == home_r);
  assign left_dec = hit_home ? left_r - 1'b1 : left_r;
  assign n_adv    = n_r + 1'b1;
  assign s_adv    = next_slot(s_r);
  assign last_cnt = stored_r - 1'b1;

  always_comb begin
    state_nxt = state_r;   clr_nxt = clr_r;     sw_nxt = sw_r;     stored_nxt = stored_r;
    req_nxt = req_r;       key_nxt = key_r;     val_nxt = val_r;   ia_nxt = ia_r;
    ib_nxt = ib_r;         h_nxt = h_r;         hk_nxt = hk_r;     mw_nxt = mw_r;
    bi_nxt = bi_r;         mc_nxt = mc_r;       home_nxt = home_r; s_nxt = s_r;
    first_nxt = first_r;   e_nxt = e_r;         fs_nxt = fs_r;     ls_nxt = ls_r;
    left_nxt = left_r;     n_nxt = n_r;         hf_nxt = hf_r;     fw_nxt = fw_r;
    ea_nxt = ea_r;         eb_nxt = eb_r;       rs_nxt = rs_r;     rv_nxt = rv_r;
    rk_nxt = rk_r;         rd_nxt = rd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_status_nxt = out_status_r; out_fval_nxt = out_fval_r; out_fkey_nxt = out_fkey_r;
    out_didx_nxt = out_didx_r;     out_total_nxt = out_total_r;
    slot_we = 1'b0; slot_wa = s_r; slot_wd = slot_rd_r; slot_re = 1'b0; slot_ra = s_r;
    entry_we = 1'b0; entry_wa = e_r; entry_wd = entry_rd_r; entry_re = 1'b0; entry_ra = e_r;

    case (state_r)
      ST_SWEEP: begin
        slot_we = 1'b1;
        slot_wa = sw_r;
        slot_wd = '0;
        sw_nxt = sw_r + 1'b1;
        if (sw_r == SLOT_LAST) begin
          sw_nxt = '0;
          state_nxt = clr_r ? ST_DONE : ST_IDLE;
          clr_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt = in_req_type;
          key_nxt = in_key & hte_pkg::KEY_MASK;
          hk_nxt = in_key & hte_pkg::KEY_MASK;
          val_nxt = in_value & hte_pkg::VAL_MASK;
          ia_nxt = in_index_a;
          ib_nxt = in_index_b;
          rs_nxt = hte_pkg::STAT_OK;
          rv_nxt = '0;
          rk_nxt = '0;
          rd_nxt = '0;
          h_nxt = hte_pkg::FNV_BASIS;
          bi_nxt = '0;
          case (in_req_type)
            hte_pkg::REQ_INSERT, hte_pkg::REQ_REMOVE, hte_pkg::REQ_FIND: state_nxt = ST_HASH;
            hte_pkg::REQ_CLEAR: begin
              stored_nxt = '0;
              clr_nxt = 1'b1;
              sw_nxt = '0;
              state_nxt = ST_SWEEP;
            end
            hte_pkg::REQ_SWAP: begin
              if (CW'(in_index_a) >= stored_r || CW'(in_index_b) >= stored_r) begin
                rs_nxt = hte_pkg::STAT_BADIDX;
                state_nxt = ST_DONE;
              end else begin
                entry_re = 1'b1;
                entry_ra = in_index_a;
                state_nxt = ST_SW_A;
              end
            end
            hte_pkg::REQ_READ: begin
              if (CW'(in_index_a) >= stored_r) begin
                rs_nxt = hte_pkg::STAT_BADIDX;
                state_nxt = ST_DONE;
              end else begin
                entry_re = 1'b1;
                entry_ra = in_index_a;
                state_nxt = ST_RE;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_HASH: begin
        h_nxt = (hx << hte_pkg::FNV_SHIFT) + hx * {55'd0, hte_pkg::FNV_LOW};
        hk_nxt = hk_r >> 8;
        bi_nxt = bi_r + 1'b1;
        if (bi_r == BI_W'(hte_pkg::KEY_BYTES - 1)) begin
          mw_nxt = h_nxt;
          home_nxt = '0;
          mc_nxt = '0;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        home_nxt = mod_chunk(home_r, mw_r[hte_pkg::KEY_W-1 -: 8]);
        mw_nxt = mw_r << 8;
        mc_nxt = mc_r + 1'b1;
        if (mc_r == MC_W'(MOD_STEPS - 1)) begin
          slot_re = 1'b1;
          slot_ra = home_nxt;
          state_nxt = ST_HC;
        end
      end
      ST_HC: begin
        left_nxt = slot_rd_r.hcount;
        s_nxt = home_r;
        first_nxt = home_r;
        n_nxt = '0;
        hf_nxt = 1'b0;
        state_nxt = (slot_rd_r.hcount == '0) ? ST_MISS : ST_PCHK;
      end
      ST_PCHK: begin
        if (!slot_rd_r.used && !hf_r) begin
          first_nxt = s_r;
          hf_nxt = 1'b1;
        end
        left_nxt = left_dec;
        s_nxt = s_adv;
        n_nxt = n_adv;
        if (hit_home && slot_rd_r.hash == h_r && CW'(slot_rd_r.entry) < SLOT_N) begin
          e_nxt = slot_rd_r.entry;
          fs_nxt = s_r;
          fw_nxt = slot_rd_r;
          entry_re = 1'b1;
          entry_ra = slot_rd_r.entry;
          state_nxt = ST_PKEY;
        end else if (left_dec == '0 || n_adv == SLOT_N) begin
          state_nxt = ST_MISS;
        end else begin
          slot_re = 1'b1;
          slot_ra = s_adv;
        end
      end
      ST_PKEY: begin
        if (entry_rd_r.key == key_r) begin
          case (req_r)
            hte_pkg::REQ_INSERT: begin
              rs_nxt = hte_pkg::STAT_DUP;
              state_nxt = ST_DONE;
            end
            hte_pkg::REQ_FIND: begin
              rd_nxt = e_r;
              rv_nxt = entry_rd_r.value;
              state_nxt = ST_DONE;
            end
            default: begin
              rd_nxt = e_r;
              slot_we = 1'b1;
              slot_wa = fs_r;
              slot_wd = fw_r;
              slot_wd.used = 1'b0;
              slot_wd.hash = '0;
              state_nxt = ST_HRD;
            end
          endcase
        end else if (left_r == '0 || n_r == SLOT_N) begin
          state_nxt = ST_MISS;
        end else begin
          slot_re = 1'b1;
          slot_ra = s_r;
          state_nxt = ST_PCHK;
        end
      end
      ST_MISS: begin
        if (req_r != hte_pkg::REQ_INSERT) begin
          rs_nxt = hte_pkg::STAT_NOTFOUND;
          state_nxt = ST_DONE;
        end else if (stored_r >= SLOT_N) begin
          rs_nxt = hte_pkg::STAT_FULL;
          state_nxt = ST_DONE;
        end else begin
          s_nxt = first_r;
          n_nxt = '0;
          slot_re = 1'b1;
          slot_ra = first_r;
          state_nxt = ST_FCHK;
        end
      end
      ST_FCHK: begin
        if (slot_rd_r.used && n_r < SLOT_N) begin
          s_nxt = s_adv;
          n_nxt = n_adv;
          slot_re = 1'b1;
          slot_ra = s_adv;
        end else begin
          slot_we = 1'b1;
          slot_wa = s_r;
          slot_wd.used = 1'b1;
          slot_wd.hash = h_r;
          slot_wd.home = home_r;
          slot_wd.entry = stored_r[SW-1:0];
          slot_wd.hcount = slot_rd_r.hcount;
          entry_we = 1'b1;
          entry_wa = stored_r[SW-1:0];
          entry_wd.key = key_r;
          entry_wd.value = val_r;
          entry_wd.slot = s_r;
          rd_nxt = stored_r[SW-1:0];
          state_nxt = ST_HRD;
        end
      end
      ST_HRD: begin
        slot_re = 1'b1;
        slot_ra = home_r;
        state_nxt = ST_HWR;
      end
      ST_HWR: begin
        slot_we = 1'b1;
        slot_wa = home_r;
        slot_wd = slot_rd_r;
        if (req_r == hte_pkg::REQ_INSERT) begin
          slot_wd.hcount = slot_rd_r.hcount + 1'b1;
          stored_nxt = stored_r + 1'b1;
          state_nxt = ST_DONE;
        end else begin
          if (slot_rd_r.hcount != '0) slot_wd.hcount = slot_rd_r.hcount - 1'b1;
          stored_nxt = last_cnt;
          if (e_r != last_cnt[SW-1:0]) begin
            entry_re = 1'b1;
            entry_ra = last_cnt[SW-1:0];
            state_nxt = ST_RM_ERD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_RM_ERD: begin
        entry_we = 1'b1;
        entry_wa = e_r;
        entry_wd = entry_rd_r;
        ls_nxt = entry_rd_r.slot;
        slot_re = 1'b1;
        slot_ra = entry_rd_r.slot;
        state_nxt = ST_RM_SWR;
      end
      ST_RM_SWR: begin
        slot_we = 1'b1;
        slot_wa = ls_r;
        slot_wd = slot_rd_r;
        slot_wd.entry = e_r;
        state_nxt = ST_DONE;
      end
      ST_SW_A: begin
        ea_nxt = entry_rd_r;
        entry_re = 1'b1;
        entry_ra = ib_r;
        state_nxt = ST_SW_B;
      end
      ST_SW_B: begin
        eb_nxt = entry_rd_r;
        entry_we = 1'b1;
        entry_wa = ia_r;
        entry_wd = entry_rd_r;
        state_nxt = ST_SW_C;
      end
      ST_SW_C: begin
        entry_we = 1'b1;
        entry_wa = ib_r;
        entry_wd = ea_r;
        slot_re = 1'b1;
        slot_ra = ea_r.slot;
        state_nxt = ST_SW_D;
      end
      ST_SW_D: begin
        slot_we = 1'b1;
        slot_wa = ea_r.slot;
        slot_wd = slot_rd_r;
        slot_wd.entry = ib_r;
        state_nxt = ST_SW_E;
      end
      ST_SW_E: begin
        slot_re = 1'b1;
        slot_ra = eb_r.slot;
        state_nxt = ST_SW_F;
      end
      ST_SW_F: begin
        slot_we = 1'b1;
        slot_wa = eb_r.slot;
        slot_wd = slot_rd_r;
        slot_wd.entry = ia_r;
        state_nxt = ST_DONE;
      end
      ST_RE: begin
        rv_nxt = entry_rd_r.value;
        rk_nxt = entry_rd_r.key;
        rd_nxt = ia_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = rs_r;
          out_fval_nxt = rv_r;
          out_fkey_nxt = rk_r;
          out_didx_nxt = rd_r;
          out_total_nxt = stored_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      clr_r <= 1'b0;
      sw_r <= '0;
      stored_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;   clr_r <= clr_nxt;     sw_r <= sw_nxt;
      stored_r <= stored_nxt; out_valid_r <= out_valid_nxt;
      req_r <= req_nxt;       key_r <= key_nxt;     val_r <= val_nxt;
      ia_r <= ia_nxt;         ib_r <= ib_nxt;       h_r <= h_nxt;
      hk_r <= hk_nxt;         mw_r <= mw_nxt;       bi_r <= bi_nxt;
      mc_r <= mc_nxt;         home_r <= home_nxt;   s_r <= s_nxt;
      first_r <= first_nxt;   e_r <= e_nxt;         fs_r <= fs_nxt;
      ls_r <= ls_nxt;         left_r <= left_nxt;   n_r <= n_nxt;
      hf_r <= hf_nxt;         fw_r <= fw_nxt;       ea_r <= ea_nxt;
      eb_r <= eb_nxt;         rs_r <= rs_nxt;       rv_r <= rv_nxt;
      rk_r <= rk_nxt;         rd_r <= rd_nxt;
      out_status_r <= out_status_nxt; out_fval_r <= out_fval_nxt;
      out_fkey_r <= out_fkey_nxt;     out_didx_r <= out_didx_nxt;
      out_total_r <= out_total_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_fval_r;
  assign out_read_key    = out_fkey_r;
  assign out_dense_index = out_didx_r;
  assign out_entry_total = out_total_r;

  `HTE_ASSERT_NOW(a_count_bound, 1'b1, stored_r <= SLOT_N, "entry count above capacity")
  `HTE_ASSERT_NOW(a_idle_no_write, state_r == ST_IDLE, !slot_we && !entry_we, "write while idle")
  `HTE_ASSERT_NOW(a_probe_bound, state_r == ST_PCHK || state_r == ST_FCHK, n_r <= SLOT_N,
    "probe walk past table size")
  `HTE_ASSERT_NEXT(a_insert_count, state_r == ST_HWR && req_r == hte_pkg::REQ_INSERT,
    stored_r == $past(stored_r) + 1'b1, "insert did not add an entry")

endmodule

### tb/sv/tb_top.sv
module tb_top;

  class hash_scoreboard;
    typedef struct {
      logic [hte_pkg::STAT_W-1:0] status;
      logic [hte_pkg::VAL_W-1:0]  fval;
      logic [hte_pkg::KEY_W-1:0]  fkey;
      logic [hte_pkg::SLOT_W-1:0] didx;
      logic [hte_pkg::CNT_W-1:0]  total;
    } result_t;

    result_t     awaited[$];
    bit          used[hte_pkg::SLOT_COUNT];
    logic [63:0] shash[hte_pkg::SLOT_COUNT];
    int          sentry[hte_pkg::SLOT_COUNT];
    int          hcnt[hte_pkg::SLOT_COUNT];
    logic [63:0] ekey[hte_pkg::SLOT_COUNT];
    logic [31:0] evalue[hte_pkg::SLOT_COUNT];
    int          eslot[hte_pkg::SLOT_COUNT];
    int          stored;
    int          errors;
    int          checked;
    int          by_status[8];

    function new();
      for (int i = 0; i < hte_pkg::SLOT_COUNT; i++) begin
        used[i] = 0; shash[i] = 0; hcnt[i] = 0;
      end
      stored = 0; errors = 0; checked = 0;
    endfunction

    function logic [63:0] fnv(logic [63:0] k);
      logic [63:0] h;
      h = hte_pkg::FNV_BASIS;
      for (int i = 0; i < hte_pkg::KEY_BYTES; i++) begin
        h = h ^ {56'd0, k[8*i +: 8]};
        h = h * hte_pkg::FNV_PRIME;
      end
      return h;
    endfunction

    function int home_of(logic [63:0] h);
      return int'(h % 64'(hte_pkg::SLOT_COUNT));
    endfunction

    function int locate(logic [63:0] k, logic [63:0] h);
      int home, left, s;
      home = home_of(h);
      left = hcnt[home];
      s = home;
      for (int n = 0; left > 0 && n < hte_pkg::SLOT_COUNT; n++) begin
        if (used[s] && home_of(shash[s]) == home) begin
          left--;
          if (shash[s] == h && ekey[sentry[s]] == k) return s;
        end
        s = (s + 1 >= hte_pkg::SLOT_COUNT) ? 0 : s + 1;
      end
      return -1;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_request(logic [hte_pkg::REQ_W-1:0] req, logic [63:0] k,
                               logic [31:0] v, logic [8:0] ia, logic [8:0] ib);
      result_t r;
      logic [63:0] h;
      int found, home, left, s, first, e, last, ls, sa, sb;
      logic [63:0] tk;
      logic [31:0] tv;
      bit have_free;
      r = '{hte_pkg::STAT_OK, '0, '0, '0, '0};
      k = k & hte_pkg::KEY_MASK;
      v = v & hte_pkg::VAL_MASK;
      h = fnv(k);
      case (req)
        hte_pkg::REQ_INSERT: begin
          if (locate(k, h) >= 0) r.status = hte_pkg::STAT_DUP;
          else if (stored >= hte_pkg::SLOT_COUNT) r.status = hte_pkg::STAT_FULL;
          else begin
            home = home_of(h);
            left = hcnt[home];
            s = home; first = home;
            have_free = !used[home];
            for (int n = 0; left > 0 && n < hte_pkg::SLOT_COUNT; n++) begin
              if (!used[s]) begin
                if (!have_free) begin
                  first = s; have_free = 1;
                end
              end else if (home_of(shash[s]) == home) left--;
              s = (s + 1 >= hte_pkg::SLOT_COUNT) ? 0 : s + 1;
            end
            s = first;
            for (int n = 0; used[s] && n < hte_pkg::SLOT_COUNT; n++)
              s = (s + 1 >= hte_pkg::SLOT_COUNT) ? 0 : s + 1;
            used[s] = 1; shash[s] = h; sentry[s] = stored;
            hcnt[home]++;
            ekey[stored] = k; evalue[stored] = v; eslot[stored] = s;
            r.didx = stored[hte_pkg::SLOT_W-1:0];
            stored++;
          end
        end
        hte_pkg::REQ_REMOVE: begin
          found = locate(k, h);
          if (found < 0) r.status = hte_pkg::STAT_NOTFOUND;
          else begin
            e = sentry[found];
            last = stored - 1;
            home = home_of(shash[found]);
            if (hcnt[home] > 0) hcnt[home]--;
            used[found] = 0; shash[found] = 0;
            r.didx = e[hte_pkg::SLOT_W-1:0];
            if (e != last) begin
              ls = eslot[last];
              ekey[e] = ekey[last]; evalue[e] = evalue[last]; eslot[e] = ls;
              sentry[ls] = e;
            end
            stored--;
          end
        end
        hte_pkg::REQ_FIND: begin
          found = locate(k, h);
          if (found < 0) r.status = hte_pkg::STAT_NOTFOUND;
          else begin
            e = sentry[found];
            r.didx = e[hte_pkg::SLOT_W-1:0];
            r.fval = evalue[e];
          end
        end
        hte_pkg::REQ_CLEAR: begin
          stored = 0;
          for (int i = 0; i < hte_pkg::SLOT_COUNT; i++) begin
            used[i] = 0; shash[i] = 0; hcnt[i] = 0;
          end
        end
        hte_pkg::REQ_SWAP: begin
          if (int'(ia) >= stored || int'(ib) >= stored) r.status = hte_pkg::STAT_BADIDX;
          else begin
            sa = eslot[ia]; sb = eslot[ib];
            tk = ekey[ia]; tv = evalue[ia];
            ekey[ia] = ekey[ib]; ekey[ib] = tk;
            evalue[ia] = evalue[ib]; evalue[ib] = tv;
            eslot[ia] = sb; eslot[ib] = sa;
            sentry[sa] = int'(ib); sentry[sb] = int'(ia);
          end
        end
        hte_pkg::REQ_READ: begin
          if (int'(ia) >= stored) r.status = hte_pkg::STAT_BADIDX;
          else begin
            r.fval = evalue[ia]; r.fkey = ekey[ia]; r.didx = ia;
          end
        end
        default: ;
      endcase
      r.total = stored[hte_pkg::CNT_W-1:0];
      awaited.push_back(r);
    endfunction

    function void check_result(logic [hte_pkg::STAT_W-1:0] st, logic [hte_pkg::VAL_W-1:0] fv,
                               logic [hte_pkg::KEY_W-1:0] fk,
                               logic [hte_pkg::SLOT_W-1:0] di,
                               logic [hte_pkg::CNT_W-1:0] tot);
      result_t r;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result word, status %0d", $time, st);
        errors++;
        return;
      end
      r = awaited.pop_front();
      checked++;
      by_status[r.status]++;
      if (st !== r.status) begin
        $display("%0t: status expected %0d got %0d", $time, r.status, st); errors++;
      end
      if (fv !== r.fval) begin
        $display("%0t: found_value expected %h got %h", $time, r.fval, fv); errors++;
      end
      if (fk !== r.fkey) begin
        $display("%0t: read_key expected %h got %h", $time, r.fkey, fk); errors++;
      end
      if (di !== r.didx) begin
        $display("%0t: dense_index expected %0d got %0d", $time, r.didx, di); errors++;
      end
      if (tot !== r.total) begin
        $display("%0t: entry_total expected %0d got %0d", $time, r.total, tot); errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [hte_pkg::REQ_W-1:0]  in_req_type;
  logic [hte_pkg::KEY_W-1:0]  in_key;
  logic [hte_pkg::VAL_W-1:0]  in_value;
  logic [hte_pkg::SLOT_W-1:0] in_index_a;
  logic [hte_pkg::SLOT_W-1:0] in_index_b;
  logic                       out_valid;
  logic                       out_ready;
  logic [hte_pkg::STAT_W-1:0] out_status;
  logic [hte_pkg::VAL_W-1:0]  out_found_value;
  logic [hte_pkg::KEY_W-1:0]  out_read_key;
  logic [hte_pkg::SLOT_W-1:0] out_dense_index;
  logic [hte_pkg::CNT_W-1:0]  out_entry_total;

  hash_scoreboard sb;
  bit             no_idle;
  int             sent;
  int             ops_sent[8];
  logic [63:0]    key_pool[$];

  hash_table_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_key(in_key), .in_value(in_value),
    .in_index_a(in_index_a), .in_index_b(in_index_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_found_value(out_found_value),
    .out_read_key(out_read_key), .out_dense_index(out_dense_index),
    .out_entry_total(out_entry_total)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("DONE: errors detected");
    $finish;
  end

  function int pick_gap();
    int p;
    p = $urandom_range(99);
    if (no_idle || p < 60) return 0;
    if (p < 96) return $urandom_range(3, 1);
    return $urandom_range(80, 20);
  endfunction

  // receiver stalls
  initial begin
    int hold;
    hold = 0;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else if (no_idle || $urandom_range(99) < 70) begin
        out_ready <= 1;
      end else begin
        out_ready <= 0;
        hold = ($urandom_range(99) < 85) ? $urandom_range(3) : $urandom_range(60, 20);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_found_value, out_read_key, out_dense_index,
                      out_entry_total);
  end

  task automatic send_word(logic [hte_pkg::REQ_W-1:0] req, logic [63:0] k, logic [31:0] v,
                           logic [8:0] ia, logic [8:0] ib);
    int gap;
    in_valid    <= 1;
    in_req_type <= req;
    in_key      <= k;
    in_value    <= v;
    in_index_a  <= ia;
    in_index_b  <= ib;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, k, v, ia, ib);
    sent++;
    ops_sent[req]++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function logic [8:0] rand_index();
    logic [31:0] u;
    u = $urandom;
    return u[8:0];
  endfunction

  // index near the live range so that both good and bad indices occur
  function logic [8:0] near_index();
    logic [31:0] u;
    u = $urandom_range(sb.stored + 2);
    return u[8:0];
  endfunction

  function logic [63:0] pool_key();
    if (key_pool.size() == 0 || $urandom_range(9) == 0) return rand_key();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  task automatic mixed_word();
    int p;
    p = $urandom_range(99);
    if (p < 32)
      send_word(hte_pkg::REQ_INSERT, pool_key(), $urandom, rand_index(), rand_index());
    else if (p < 52)
      send_word(hte_pkg::REQ_REMOVE, pool_key(), $urandom, rand_index(), rand_index());
    else if (p < 76)
      send_word(hte_pkg::REQ_FIND, pool_key(), $urandom, rand_index(), rand_index());
    else if (p < 86)
      send_word(hte_pkg::REQ_SWAP, rand_key(), $urandom, near_index(), near_index());
    else if (p < 95)
      send_word(hte_pkg::REQ_READ, rand_key(), $urandom, near_index(), rand_index());
    else if (p < 97)
      send_word(hte_pkg::REQ_CLEAR, rand_key(), $urandom, rand_index(), rand_index());
    else
      send_word(3'(6 + $urandom_range(1)), rand_key(), $urandom, rand_index(), rand_index());
  endtask

  task automatic drain();
    while (sb.pending() > 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] k;
    sb = new();
    sent = 0;
    no_idle = 0;
    rst_n = 0;
    in_valid = 0;
    in_req_type = hte_pkg::REQ_INSERT;
    in_key = '0;
    in_value = '0;
    in_index_a = '0;
    in_index_b = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // directed words
    send_word(hte_pkg::REQ_READ, 64'd0, 32'd0, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_SWAP, 64'd0, 32'd0, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_FIND, 64'd0, 32'd0, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_INSERT, 64'd0, 32'hffffffff, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_INSERT, '1, 32'd0, 9'h1ff, 9'h1ff);
    send_word(hte_pkg::REQ_INSERT, 64'h0000000000000100, 32'h5a5aa5a5, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_INSERT, 64'd0, 32'd7, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_FIND, 64'd0, 32'd0, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_FIND, '1, 32'd0, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_FIND, 64'h8000000000000000, 32'd0, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_REMOVE, 64'd12345, 32'd0, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_READ, 64'd0, 32'd0, 9'd2, 9'd0);
    send_word(hte_pkg::REQ_READ, 64'd0, 32'd0, 9'd3, 9'd0);
    send_word(hte_pkg::REQ_READ, 64'd0, 32'd0, 9'h1ff, 9'd0);
    send_word(hte_pkg::REQ_SWAP, 64'd0, 32'd0, 9'd0, 9'd2);
    send_word(hte_pkg::REQ_SWAP, 64'd0, 32'd0, 9'd1, 9'd1);
    send_word(hte_pkg::REQ_SWAP, 64'd0, 32'd0, 9'd0, 9'd3);
    send_word(3'd6, '1, '1, '1, '1);
    send_word(3'd7, 64'd0, 32'd0, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_REMOVE, 64'd0, 32'd0, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_READ, 64'd0, 32'd0, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_CLEAR, 64'd0, 32'd0, 9'd0, 9'd0);
    send_word(hte_pkg::REQ_FIND, '1, 32'd0, 9'd0, 9'd0);

    // mixed traffic over a small key pool so that hits and collisions are common
    for (int i = 0; i < 48; i++) begin
      k = ($urandom_range(2) == 0) ? 64'($urandom_range(255)) : rand_key();
      key_pool.push_back(k);
    end
    repeat (380) mixed_word();

    // hold off until the engine has returned everything
    in_valid <= 0;
    drain();

    // fill to capacity, overflow, then work on a full table
    key_pool.delete();
    send_word(hte_pkg::REQ_CLEAR, rand_key(), $urandom, rand_index(), rand_index());
    while (sb.stored < hte_pkg::SLOT_COUNT) begin
      k = rand_key();
      key_pool.push_back(k);
      send_word(hte_pkg::REQ_INSERT, k, $urandom, rand_index(), rand_index());
    end
    repeat (6) send_word(hte_pkg::REQ_INSERT, pool_key(), $urandom, rand_index(), rand_index());
    repeat (60) send_word(hte_pkg::REQ_FIND, pool_key(), $urandom, rand_index(), rand_index());
    repeat (30) send_word(hte_pkg::REQ_SWAP, rand_key(), $urandom, rand_index(), rand_index());
    repeat (30) send_word(hte_pkg::REQ_READ, rand_key(), $urandom, rand_index(), rand_index());
    repeat (80) send_word(hte_pkg::REQ_REMOVE, pool_key(), $urandom, rand_index(), rand_index());
    repeat (20) send_word(hte_pkg::REQ_INSERT, pool_key(), $urandom, rand_index(), rand_index());

    // back-to-back stretch with no idling on either side
    no_idle = 1;
    repeat (150) mixed_word();
    no_idle = 0;
    repeat (120) mixed_word();

    in_valid <= 0;
    drain();
    repeat (1200) @(posedge clk);
    $display("%0d words sent: %0d insert, %0d remove, %0d find, %0d clear, %0d swap, %0d read",
             sent, ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3], ops_sent[4],
             ops_sent[5]);
    $display("%0d results checked: %0d ok, %0d missing, %0d dup, %0d full, %0d bad index",
             sb.checked, sb.by_status[0], sb.by_status[1], sb.by_status[2],
             sb.by_status[3], sb.by_status[4]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/hte_pkg.sv
rtl/core/hash_table_engine.sv
tb/sv/tb_top.sv
